@@ design/szn_pkg.sv @@
`default_nettype none

package szn_pkg;

   localparam int MAX_SITES = 256;
   localparam int SITE_W    = $clog2(MAX_SITES);
   localparam int CNT_W     = $clog2(MAX_SITES + 1);
   localparam int PROB_W    = 16;
   localparam int CSR_W     = 16;

   localparam logic [CNT_W-1:0] LATTICE_MIN = CNT_W'(3);
   localparam logic [CNT_W-1:0] LATTICE_MAX = CNT_W'(MAX_SITES);

   // item kinds carried in req_tuser
   localparam logic [1:0] FN_CLEAR  = 2'd0;
   localparam logic [1:0] FN_SEED   = 2'd1;
   localparam logic [1:0] FN_UPDATE = 2'd2;

   // configuration register indexes
   localparam logic CSR_LATTICE_SIZE    = 1'b0;
   localparam logic CSR_LONG_RANGE_PROB = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RD_PAIR,
      ST_RD_TGT,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic load;     // capture the accepted item
      logic rd_pair;  // read site and its right neighbour
      logic rd_tgt;   // read the copy target, keep the pair
      logic exec;     // write the ring, count and result
   } cmd_type;

   typedef struct packed {
      logic out_free; // result register can take a new result
   } stat_type;

   // idx + d modulo size, for idx < size and d <= 2
   function automatic logic [CNT_W-1:0] wrap_add(input logic [SITE_W-1:0] idx,
                                                 input logic [1:0]        d,
                                                 input logic [CNT_W-1:0]  size);
      logic [CNT_W-1:0] sum;
      begin
         sum = CNT_W'(idx) + CNT_W'(d);
         wrap_add = (sum >= size) ? sum - size : sum;
      end
   endfunction

endpackage

`default_nettype wire

@@ design/szn_ctrl.sv @@
`default_nettype none

module szn_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire szn_pkg::stat_type stat,
   output szn_pkg::cmd_type       cmd
);

   szn_pkg::state_type state_ff;
   szn_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= szn_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         szn_pkg::ST_IDLE: begin
            // take no transfer while reset is high
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.load = 1'b1;
               state_in = szn_pkg::ST_RD_PAIR;
            end
         end
         szn_pkg::ST_RD_PAIR: begin
            cmd.rd_pair = 1'b1;
            state_in    = szn_pkg::ST_RD_TGT;
         end
         szn_pkg::ST_RD_TGT: begin
            cmd.rd_tgt = 1'b1;
            state_in   = szn_pkg::ST_EXEC;
         end
         szn_pkg::ST_EXEC: begin
            // hold until the result register is free
            if (stat.out_free) begin
               cmd.exec = 1'b1;
               state_in = szn_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = szn_pkg::ST_IDLE;
         end
      endcase
   end

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.rd_pair, cmd.rd_tgt, cmd.exec}))
      else $error("more than one datapath command at once");

   a_read_order: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_pair |=> cmd.rd_tgt)
      else $error("target read did not follow pair read");

endmodule

`default_nettype wire

@@ design/szn_dpath.sv @@
`default_nettype none

module szn_dpath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire szn_pkg::cmd_type            cmd,
   output szn_pkg::stat_type                stat,
   input  wire logic [1:0]                  req_func,
   input  wire logic [szn_pkg::SITE_W-1:0]  req_site,
   input  wire logic [szn_pkg::SITE_W-1:0]  req_far_site,
   input  wire logic [szn_pkg::PROB_W-1:0]  req_prob_draw,
   input  wire logic                        req_coin,
   input  wire logic                        csr_write,
   input  wire logic                        csr_index,
   input  wire logic [szn_pkg::CSR_W-1:0]   csr_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_accepted,
   output logic                             rsp_changed,
   output logic [szn_pkg::CNT_W-1:0]        rsp_up_count,
   output logic                             rsp_consensus,
   output logic                             rsp_bad_index
);

   // captured item
   logic [1:0]                 func_ff;
   logic [szn_pkg::SITE_W-1:0] site_ff;
   logic [szn_pkg::SITE_W-1:0] far_ff;
   logic [szn_pkg::PROB_W-1:0] draw_ff;
   logic                       coin_ff;

   // configuration
   logic [szn_pkg::CNT_W-1:0]  size_ff;
   logic [szn_pkg::CNT_W-1:0]  size_in;
   logic [szn_pkg::PROB_W-1:0] prob_ff;

   // ring store: memory plus one valid bit per site, cleared at once
   logic                         opin_mem [szn_pkg::MAX_SITES];
   logic [szn_pkg::MAX_SITES-1:0] valid_ff;
   logic                         rd_a_ff;
   logic                         rd_b_ff;
   logic                         pair_eq_ff;
   logic                         pair_val_ff;
   logic [szn_pkg::CNT_W-1:0]    up_total_ff;
   logic [szn_pkg::CNT_W-1:0]    up_total_in;

   // result register
   logic                      rsp_valid_ff;
   logic                      rsp_acc_ff;
   logic                      rsp_chg_ff;
   logic [szn_pkg::CNT_W-1:0] rsp_cnt_ff;
   logic                      rsp_cons_ff;
   logic                      rsp_bad_ff;

   logic [szn_pkg::SITE_W-1:0] right_idx;
   logic [szn_pkg::SITE_W-1:0] fwd2_idx;
   logic [szn_pkg::SITE_W-1:0] left_idx;
   logic [szn_pkg::SITE_W-1:0] tgt_idx;
   logic [szn_pkg::SITE_W-1:0] addr_a;
   logic [szn_pkg::CNT_W-1:0]  left_wide;
   logic                       draw_lt;
   logic                       draw_eq;
   logic                       bad_site;
   logic                       bad_far;
   logic                       bad;
   logic                       acc;
   logic                       chg;
   logic                       wr_en;
   logic [szn_pkg::SITE_W-1:0] wr_addr;
   logic                       wr_val;
   logic                       clear_ring;
   logic [szn_pkg::CNT_W-1:0]  csr_size;

   // capture the item
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         site_ff <= req_site;
         far_ff  <= req_far_site;
         draw_ff <= req_prob_draw;
         coin_ff <= req_coin;
      end
   end

   // clamp the size to the legal range
   always_comb begin
      csr_size = csr_data[szn_pkg::CNT_W-1:0];
      priority if (csr_size < szn_pkg::LATTICE_MIN) begin
         size_in = szn_pkg::LATTICE_MIN;
      end else if (csr_size > szn_pkg::LATTICE_MAX) begin
         size_in = szn_pkg::LATTICE_MAX;
      end else begin
         size_in = csr_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= szn_pkg::LATTICE_MAX;
         prob_ff <= '0;
      end else if (csr_write) begin
         if (csr_index == szn_pkg::CSR_LATTICE_SIZE) begin
            size_ff <= size_in;
         end else begin
            prob_ff <= csr_data[szn_pkg::PROB_W-1:0];
         end
      end
   end

   // neighbour and target addresses
   always_comb begin
      right_idx = szn_pkg::SITE_W'(szn_pkg::wrap_add(site_ff, 2'd1, size_ff));
      fwd2_idx  = szn_pkg::SITE_W'(szn_pkg::wrap_add(site_ff, 2'd2, size_ff));
      left_wide = (site_ff == '0) ? size_ff - szn_pkg::CNT_W'(1)
                                  : szn_pkg::CNT_W'(site_ff) - szn_pkg::CNT_W'(1);
      left_idx  = left_wide[szn_pkg::SITE_W-1:0];
      draw_lt   = draw_ff < prob_ff;
      draw_eq   = draw_ff == prob_ff;
      if (draw_lt) begin
         tgt_idx = far_ff;
      end else if (coin_ff) begin
         tgt_idx = fwd2_idx;
      end else begin
         tgt_idx = left_idx;
      end
      addr_a = cmd.rd_pair ? site_ff : tgt_idx;
   end

   // registered reads; an entry never written since the last clear reads down
   always_ff @(posedge clock) begin
      if (cmd.rd_pair || cmd.rd_tgt) begin
         rd_a_ff <= opin_mem[addr_a] & valid_ff[addr_a];
      end
      if (cmd.rd_pair) begin
         rd_b_ff <= opin_mem[right_idx] & valid_ff[right_idx];
      end
      if (wr_en) begin
         opin_mem[wr_addr] <= wr_val;
      end
   end

   // keep the pair while the target is read
   always_ff @(posedge clock) begin
      if (cmd.rd_tgt) begin
         pair_eq_ff  <= rd_a_ff == rd_b_ff;
         pair_val_ff <= rd_a_ff;
      end
   end

   // item execution
   always_comb begin
      bad_site    = szn_pkg::CNT_W'(site_ff) >= size_ff;
      bad_far     = szn_pkg::CNT_W'(far_ff) >= size_ff;
      bad         = 1'b0;
      acc         = 1'b0;
      chg         = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = tgt_idx;
      wr_val      = pair_val_ff;
      clear_ring  = 1'b0;
      up_total_in = up_total_ff;
      unique case (func_ff)
         szn_pkg::FN_CLEAR: begin
            clear_ring = 1'b1;
         end
         szn_pkg::FN_SEED: begin
            wr_addr = site_ff;
            wr_val  = 1'b1;
            if (bad_site) begin
               bad = 1'b1;
            end else if (!pair_val_ff) begin
               acc = 1'b1;
               chg = 1'b1;
            end
         end
         szn_pkg::FN_UPDATE: begin
            if (bad_site || bad_far) begin
               bad = 1'b1;
            end else if (pair_eq_ff) begin
               acc = 1'b1;
               chg = !draw_eq && (rd_a_ff != pair_val_ff);
            end
         end
         default: begin
         end
      endcase
      if (!cmd.exec) begin
         clear_ring = 1'b0;
         chg        = 1'b0;
      end
      wr_en = chg;
      if (clear_ring) begin
         up_total_in = '0;
      end else if (chg) begin
         up_total_in = wr_val ? up_total_ff + szn_pkg::CNT_W'(1)
                              : up_total_ff - szn_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         up_total_ff <= '0;
      end else if (csr_write && csr_index == szn_pkg::CSR_LATTICE_SIZE) begin
         valid_ff    <= '0;
         up_total_ff <= '0;
      end else begin
         if (clear_ring) begin
            valid_ff <= '0;
         end else if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         up_total_ff <= up_total_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.exec) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_acc_ff  <= acc;
         rsp_chg_ff  <= wr_en;
         rsp_cnt_ff  <= up_total_in;
         rsp_cons_ff <= (up_total_in == '0) || (up_total_in == size_ff);
         rsp_bad_ff  <= bad;
      end
   end

   assign stat.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accepted   = rsp_acc_ff;
   assign rsp_changed    = rsp_chg_ff;
   assign rsp_up_count   = rsp_cnt_ff;
   assign rsp_consensus  = rsp_cons_ff;
   assign rsp_bad_index  = rsp_bad_ff;

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      up_total_ff <= size_ff)
      else $error("up count exceeds ring size");

   a_count_steady: assert property (@(posedge clock) disable iff (reset)
      !cmd.exec && !csr_write |=> $stable(up_total_ff))
      else $error("up count moved without an item or register write");

   a_flags_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_chg_ff || rsp_acc_ff) && !(rsp_bad_ff && rsp_acc_ff))
      else $error("result flags contradict each other");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && func_ff == szn_pkg::FN_CLEAR |=> up_total_ff == '0)
      else $error("clear left up sites");

endmodule

`default_nettype wire

@@ design/sznajd_ring_update_step_top.sv @@
`default_nettype none

// Sznajd opinion ring: one-bit opinions on a ring of up to 256 sites.
//
// req_ channel: one item per transfer; req_tuser selects clear, seed or
// update, req_tdata carries the site, long-range site, draw and coin.
// rsp_ channel: exactly one result per item, in item order, with the
// accepted and changed flags, running up count, consensus and bad index.
// csr_ channel: register writes (0 lattice size, 1 long-range probability),
// taken in every cycle outside reset; issue them only while no item is in
// flight. A size write clamps to 3..256 and clears the ring.
//
// Timing: an item is taken in the idle state, then the pair is read, then
// the copy target is read from the same single-write ring memory, then the
// ring, count and result register are written. The result shows on rsp_
// from the result register, and the next item is taken back in the idle
// state: the block takes no new item until the last one is written.
// When the receiver stalls, the finished result holds in the output
// register; a following item proceeds up to its write step and waits there.
// Reset: ring all down, count zero, size 256, probability zero, no result.

module sznajd_ring_update_step_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: site [7:0], far_site [15:8], prob_draw [31:16], coin [32],
   //            zero [39:33]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,
   // req_tuser: func [1:0]
   input  wire logic [1:0]  req_tuser,
   // rsp_tdata: accepted [0], changed [1], up_count [10:2], consensus [11],
   //            bad_index [12], zero [15:13]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_data
);

   szn_pkg::cmd_type  cmd;
   szn_pkg::stat_type stat;

   logic                      rsp_accepted;
   logic                      rsp_changed;
   logic [szn_pkg::CNT_W-1:0] rsp_up_count;
   logic                      rsp_consensus;
   logic                      rsp_bad_index;

   // configuration writes never stall outside reset
   assign csr_ready = !reset;

   szn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   szn_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_func      (req_tuser),
      .req_site      (req_tdata[7:0]),
      .req_far_site  (req_tdata[15:8]),
      .req_prob_draw (req_tdata[31:16]),
      .req_coin      (req_tdata[32]),
      .csr_write     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_accepted  (rsp_accepted),
      .rsp_changed   (rsp_changed),
      .rsp_up_count  (rsp_up_count),
      .rsp_consensus (rsp_consensus),
      .rsp_bad_index (rsp_bad_index)
   );

   // pack the result, first field lowest
   assign rsp_tdata = {3'b000, rsp_bad_index, rsp_consensus, rsp_up_count,
                       rsp_changed, rsp_accepted};

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // func code that the block leaves without effect
   localparam logic [1:0] FN_SPARE = 2'd3;

   // phases of random traffic, and transfers per phase
   localparam int PHASES     = 10;
   localparam int PHASE_LEN  = 163;
   // cycles without any transfer before the run is abandoned
   localparam int STALL_LIMIT = 3000;
   // receiver hold-off that backs the block up into its input
   localparam int STARVE_CYCLES = 300;

   // one result, as unpacked from rsp_tdata
   typedef struct packed {
      logic                      accepted;
      logic                      changed;
      logic [szn_pkg::CNT_W-1:0] up_count;
      logic                      consensus;
      logic                      bad_index;
   } ring_result_type;

   // Mirror of the opinion ring: predicts one result per input transfer and
   // checks the results in order against it.
   class ring_tracker;
      bit                         opinion[szn_pkg::MAX_SITES];
      int unsigned                up_total;
      int unsigned                lattice_size;
      bit [szn_pkg::PROB_W-1:0]   long_range_prob;
      ring_result_type            expected_q[$];
      int                         errors;

      function new();
         clear_ring();
         lattice_size    = szn_pkg::MAX_SITES;
         long_range_prob = '0;
         errors          = 0;
      endfunction

      function void clear_ring();
         foreach (opinion[i]) opinion[i] = 1'b0;
         up_total = 0;
      endfunction

      function int unsigned wrap_index(int unsigned idx, int unsigned d);
         int unsigned v;
         v = idx + d;
         return (v >= lattice_size) ? v - lattice_size : v;
      endfunction

      // set one site, keep the count, report a flip
      function bit put_opinion(int unsigned idx, bit v);
         if (opinion[idx] == v) return 1'b0;
         opinion[idx] = v;
         if (v) up_total++;
         else up_total--;
         return 1'b1;
      endfunction

      function void write_reg(logic index, logic [15:0] data);
         int unsigned v;
         if (index == szn_pkg::CSR_LATTICE_SIZE) begin
            // only the low nine bits count; clamp, then start from an empty ring
            v = 32'(data[8:0]);
            if (v < 3) v = 3;
            if (v > szn_pkg::MAX_SITES) v = szn_pkg::MAX_SITES;
            lattice_size = v;
            clear_ring();
         end else begin
            long_range_prob = data[szn_pkg::PROB_W-1:0];
         end
      endfunction

      function void take_item(logic [1:0] fn, logic [39:0] data);
         int unsigned              s;
         int unsigned              far;
         int unsigned              tgt;
         bit [szn_pkg::PROB_W-1:0] draw;
         bit                       coin;
         bit                       v;
         ring_result_type          r;
         s    = 32'(data[7:0]);
         far  = 32'(data[15:8]);
         draw = data[31:16];
         coin = data[32];
         r    = '0;
         case (fn)
            szn_pkg::FN_CLEAR: clear_ring();
            szn_pkg::FN_SEED: begin
               if (s >= lattice_size) begin
                  r.bad_index = 1'b1;
               end else if (!opinion[s]) begin
                  r.changed  = put_opinion(s, 1'b1);
                  r.accepted = 1'b1;
               end
            end
            szn_pkg::FN_UPDATE: begin
               if (s >= lattice_size || far >= lattice_size) begin
                  r.bad_index = 1'b1;
               end else if (opinion[s] == opinion[wrap_index(s, 1)]) begin
                  v          = opinion[s];
                  r.accepted = 1'b1;
                  // draw equal to p copies nothing
                  if (draw < long_range_prob) begin
                     r.changed = put_opinion(far, v);
                  end else if (draw > long_range_prob) begin
                     tgt = coin ? wrap_index(s, 2)
                                : (s == 0 ? lattice_size - 1 : s - 1);
                     r.changed = put_opinion(tgt, v);
                  end
               end
            end
            default: ;
         endcase
         r.up_count  = szn_pkg::CNT_W'(up_total);
         r.consensus = (up_total == 0 || up_total == lattice_size);
         expected_q.push_back(r);
      endfunction

      function void check_field(string name, logic [szn_pkg::CNT_W-1:0] want,
                                logic [szn_pkg::CNT_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void take_result(logic [15:0] data);
         ring_result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: result %h with none expected", $time, data);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         check_field("accepted", szn_pkg::CNT_W'(want.accepted),
                     szn_pkg::CNT_W'(data[0]));
         check_field("changed", szn_pkg::CNT_W'(want.changed),
                     szn_pkg::CNT_W'(data[1]));
         check_field("up_count", want.up_count, data[10:2]);
         check_field("consensus", szn_pkg::CNT_W'(want.consensus),
                     szn_pkg::CNT_W'(data[11]));
         check_field("bad_index", szn_pkg::CNT_W'(want.bad_index),
                     szn_pkg::CNT_W'(data[12]));
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [15:0] csr_data;

   ring_tracker tracker = new();

   // calm: no idling on either side; starve_request: ask the receiver for
   // one long hold-off, which it counts out itself
   bit          calm;
   bit          starve_request;
   int          idle_cycles;

   sznajd_ring_update_step_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Observe every transfer at the rising edge. Inputs only move on the
   // falling edge, so the values seen here are the ones the block took.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) tracker.write_reg(csr_index, csr_data);
         if (req_tvalid && req_tready) tracker.take_item(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) tracker.take_result(rsp_tdata);
      end
   end

   // Watchdog: abandon the run when nothing moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (csr_valid && csr_ready) || (req_tvalid && req_tready)
          || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: short stalls mostly, now and then a long one, none when calm.
   initial begin : result_sink
      int stall_left;
      int starve_left;
      int r;
      stall_left  = 0;
      starve_left = 0;
      rsp_tready  = 1'b0;
      forever begin
         @(negedge clock);
         if (starve_request) begin
            starve_request = 1'b0;
            starve_left    = STARVE_CYCLES;
         end
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (starve_left > 0) begin
            rsp_tready <= 1'b0;
            starve_left--;
         end else if (calm) begin
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            r = $urandom_range(0, 99);
            if (r < 20) stall_left = $urandom_range(1, 3);
            else if (r < 23) stall_left = $urandom_range(20, 60);
         end
      end
   end

   // sender idling: mostly back to back or short, a few long gaps
   function automatic int sender_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one item and hold it until the block takes the transfer. A gap
   // lowers tvalid for that many cycles first; without one, tvalid stays up.
   task automatic send_item(input logic [1:0] fn, input logic [7:0] site,
                            input logic [7:0] far, input logic [15:0] draw,
                            input logic coin);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= {7'd0, coin, draw, far, site};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic stop_items();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_for_results();
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [15:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random item, shaped so that most indices land on the ring in use and a
   // fair share of draws sit exactly on, or next to, the threshold.
   task automatic random_item();
      logic [1:0]  fn;
      logic [7:0]  site;
      logic [7:0]  far;
      logic [15:0] draw;
      logic        coin;
      int          r;
      int unsigned top;
      top = tracker.lattice_size - 1;
      r   = $urandom_range(0, 99);
      if (r < 4) fn = szn_pkg::FN_CLEAR;
      else if (r < 6) fn = FN_SPARE;
      else if (r < 38) fn = szn_pkg::FN_SEED;
      else fn = szn_pkg::FN_UPDATE;
      site = ($urandom_range(0, 99) < 88) ? 8'($urandom_range(0, top))
                                          : 8'($urandom_range(0, 255));
      far  = ($urandom_range(0, 99) < 88) ? 8'($urandom_range(0, top))
                                          : 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 12) draw = tracker.long_range_prob;
      else if (r < 15) draw = tracker.long_range_prob + 16'd1;
      else if (r < 18) draw = tracker.long_range_prob - 16'd1;
      else draw = 16'($urandom_range(0, 65535));
      coin = 1'($urandom_range(0, 1));
      send_item(fn, site, far, draw, coin);
   endtask

   initial begin : stimulus
      logic [15:0] size_raw[PHASES];
      logic [15:0] prob_raw[PHASES];
      logic [15:0] prob;
      int          ph;
      int          n;

      // size words with stray upper bits, below the floor and above the ceiling
      size_raw = '{16'd4, 16'd0, 16'd8, 16'hFFFF, 16'd3,
                   16'd5, 16'd300, 16'd16, 16'd6, 16'h0107};
      prob_raw = '{16'h0000, 16'hFFFF, 16'h8000, 16'h4000, 16'hFFFF,
                   16'h0001, 16'hC000, 16'h0000, 16'hFFFE, 16'h2000};

      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = szn_pkg::FN_CLEAR;
      csr_valid      = 1'b0;
      csr_index      = szn_pkg::CSR_LATTICE_SIZE;
      csr_data       = '0;
      calm           = 1'b0;
      starve_request = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, at the reset setting (full ring, p zero).
      send_item(szn_pkg::FN_CLEAR, 8'd0, 8'd0, 16'd0, 1'b0);
      send_item(FN_SPARE, 8'hFF, 8'hFF, 16'hFFFF, 1'b1);
      send_item(szn_pkg::FN_SEED, 8'd0, 8'd0, 16'd0, 1'b0);
      send_item(szn_pkg::FN_SEED, 8'd255, 8'd0, 16'd0, 1'b0);
      send_item(szn_pkg::FN_SEED, 8'd0, 8'd0, 16'd0, 1'b0);          // already up
      send_item(szn_pkg::FN_UPDATE, 8'd255, 8'd0, 16'd0, 1'b1);      // draw on p, wraps
      send_item(szn_pkg::FN_UPDATE, 8'd255, 8'd128, 16'hFFFF, 1'b1); // right copy wraps
      send_item(szn_pkg::FN_UPDATE, 8'd0, 8'd0, 16'd1, 1'b0);        // left copy wraps
      send_item(szn_pkg::FN_UPDATE, 8'd2, 8'd0, 16'd5, 1'b0);        // down copied left
      send_item(szn_pkg::FN_UPDATE, 8'd0, 8'd0, 16'd5, 1'b1);        // pair disagrees
      send_item(szn_pkg::FN_UPDATE, 8'd128, 8'd255, 16'd100, 1'b1);
      stop_items();
      wait_for_results();
      repeat (4) @(posedge clock);

      // Smallest ring, by a size word under the floor; p at one half.
      write_csr(szn_pkg::CSR_LATTICE_SIZE, 16'd2);
      write_csr(szn_pkg::CSR_LONG_RANGE_PROB, 16'h8000);
      send_item(szn_pkg::FN_SEED, 8'd3, 8'd0, 16'd0, 1'b0);          // site off the ring
      send_item(szn_pkg::FN_SEED, 8'd255, 8'd0, 16'd0, 1'b0);
      send_item(szn_pkg::FN_UPDATE, 8'd0, 8'd3, 16'd0, 1'b0);        // far site off the ring
      send_item(szn_pkg::FN_UPDATE, 8'd3, 8'd0, 16'h8000, 1'b1);     // site off the ring
      send_item(szn_pkg::FN_UPDATE, 8'd0, 8'd2, 16'h8000, 1'b0);     // draw on p
      send_item(szn_pkg::FN_SEED, 8'd1, 8'd0, 16'd0, 1'b0);
      send_item(szn_pkg::FN_UPDATE, 8'd2, 8'd1, 16'd0, 1'b0);        // long-range copy down
      send_item(szn_pkg::FN_SEED, 8'd0, 8'd0, 16'd0, 1'b0);
      send_item(szn_pkg::FN_SEED, 8'd1, 8'd0, 16'd0, 1'b0);
      send_item(szn_pkg::FN_UPDATE, 8'd0, 8'd2, 16'h7FFF, 1'b0);     // reaches all up
      send_item(szn_pkg::FN_UPDATE, 8'd2, 8'd0, 16'hFFFF, 1'b1);     // s+2 wraps to 1
      send_item(szn_pkg::FN_SEED, 8'd2, 8'd0, 16'd0, 1'b0);
      send_item(szn_pkg::FN_CLEAR, 8'hFF, 8'hFF, 16'hFFFF, 1'b1);

      // Random phases, each from a clean ring at its own size and p.
      for (ph = 0; ph < PHASES; ph++) begin
         stop_items();
         wait_for_results();
         repeat (4) @(posedge clock);
         calm = (ph == 2);
         prob = (ph == 7) ? 16'($urandom_range(1, 65534)) : prob_raw[ph];
         if (ph % 2 == 0) begin
            write_csr(szn_pkg::CSR_LONG_RANGE_PROB, prob);
            write_csr(szn_pkg::CSR_LATTICE_SIZE, size_raw[ph]);
         end else begin
            write_csr(szn_pkg::CSR_LATTICE_SIZE, size_raw[ph]);
            write_csr(szn_pkg::CSR_LONG_RANGE_PROB, prob);
         end
         for (n = 0; n < PHASE_LEN; n++) begin
            // hold the receiver off while items keep coming, so the block
            // backs up and stalls its input
            if (ph == 0 && n == 40) starve_request = 1'b1;
            // pause the sender until the block has drained
            if (ph == 4 && n == 80) begin
               stop_items();
               wait_for_results();
            end
            random_item();
         end
      end

      stop_items();
      wait_for_results();
      repeat (12) @(posedge clock);
      if (tracker.errors == 0 && tracker.outstanding() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
design/szn_pkg.sv
design/szn_ctrl.sv
design/szn_dpath.sv
design/sznajd_ring_update_step_top.sv
bench/testbench.sv
